/* sv/sjag_pkg.sv */
// Shared types, constants and the arctangent table of the sidewinding joint angle generator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sjag_pkg;

  localparam int PHASE_BITS    = 16;
  localparam int PHASE_W       = 32;
  localparam int CORDIC_STAGES = 24;
  localparam int CW            = 34;
  localparam int STAGE_IDX_W   = $clog2(CORDIC_STAGES);
  localparam int JOINT_W       = 6;
  localparam int TIME_W        = 32;
  localparam int AMP_W         = 16;
  localparam int RATE_W        = 24;
  localparam int STEP_W        = 16;
  localparam int ANGLE_W       = 17;
  localparam int MAG_W         = 32;
  localparam int PROD_W        = AMP_W + MAG_W;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;

  // Only the top PHASE_BITS bits of the 32-bit phase take part in the sine.
  localparam logic [PHASE_W-1:0] PHASE_MASK =
    ~((PHASE_W'(1) << (PHASE_W - PHASE_BITS)) - PHASE_W'(1));

  localparam logic signed [CW-1:0] CORDIC_X0    = CW'(652032874);
  localparam logic signed [CW-1:0] QUARTER_TURN = CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] HALF_TURN    = CW'(64'sd2147483648);
  localparam logic [PROD_W:0]      ROUND_HALF   = (PROD_W+1)'(1) << 29;

  localparam logic [AMP_W-1:0]  AMP_EVEN_RST = 16'd6400;
  localparam logic [AMP_W-1:0]  AMP_ODD_RST  = 16'd2048;
  localparam logic [RATE_W-1:0] RATE_RST     = 24'd32752;
  localparam logic [STEP_W-1:0] STEP_RST     = 16'd21835;

  typedef enum logic [2:0] {
    REG_AMP_EVEN   = 3'd0,
    REG_AMP_ODD    = 3'd1,
    REG_RATE_EVEN  = 3'd2,
    REG_RATE_ODD   = 3'd3,
    REG_STEP_EVEN  = 3'd4,
    REG_STEP_ODD   = 3'd5,
    REG_ODD_OFFSET = 3'd6,
    REG_REVERSE    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [AMP_W-1:0]  amplitude_even;
    logic [AMP_W-1:0]  amplitude_odd;
    logic [RATE_W-1:0] rate_even;
    logic [RATE_W-1:0] rate_odd;
    logic [STEP_W-1:0] step_even;
    logic [STEP_W-1:0] step_odd;
    logic [STEP_W-1:0] odd_offset;
    logic              reverse;
  } cfg_t;

  // One item on its way through the rotation stages.
  typedef struct packed {
    logic                   valid;
    logic [JOINT_W-1:0]     joint;
    logic                   neg;
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic signed [CW-1:0]   z;
  } cordic_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic signed [CW-1:0] atan_turn(input logic [STAGE_IDX_W-1:0] idx);
    logic signed [CW-1:0] v;
    case (idx)
      5'd0:  v = CW'(536870912);
      5'd1:  v = CW'(316933406);
      5'd2:  v = CW'(167458907);
      5'd3:  v = CW'(85004756);
      5'd4:  v = CW'(42667331);
      5'd5:  v = CW'(21354465);
      5'd6:  v = CW'(10679838);
      5'd7:  v = CW'(5340245);
      5'd8:  v = CW'(2670163);
      5'd9:  v = CW'(1335086);
      5'd10: v = CW'(667544);
      5'd11: v = CW'(333772);
      5'd12: v = CW'(166886);
      5'd13: v = CW'(83443);
      5'd14: v = CW'(41721);
      5'd15: v = CW'(20860);
      5'd16: v = CW'(10430);
      5'd17: v = CW'(5215);
      5'd18: v = CW'(2607);
      5'd19: v = CW'(1303);
      5'd20: v = CW'(651);
      5'd21: v = CW'(325);
      5'd22: v = CW'(162);
      5'd23: v = CW'(81);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* sv/sjag_regs.sv */
// Configuration register file of the sidewinding joint angle generator, APB-style port.
// Depends on sjag_pkg.
`timescale 1ns / 1ps

module sjag_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sjag_pkg::ADDR_W-1:0] paddr,
  input  logic [sjag_pkg::DATA_W-1:0] pwdata,
  output logic [sjag_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output sjag_pkg::cfg_t              cfg
);

  sjag_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = sjag_pkg::reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.amplitude_even <= sjag_pkg::AMP_EVEN_RST;
      cfg.amplitude_odd  <= sjag_pkg::AMP_ODD_RST;
      cfg.rate_even      <= sjag_pkg::RATE_RST;
      cfg.rate_odd       <= sjag_pkg::RATE_RST;
      cfg.step_even      <= sjag_pkg::STEP_RST;
      cfg.step_odd       <= sjag_pkg::STEP_RST;
      cfg.odd_offset     <= '0;
      cfg.reverse        <= 1'b0;
    end else if (wr) begin
      case (idx)
        sjag_pkg::REG_AMP_EVEN:   cfg.amplitude_even <= pwdata[15:0];
        sjag_pkg::REG_AMP_ODD:    cfg.amplitude_odd  <= pwdata[15:0];
        sjag_pkg::REG_RATE_EVEN:  cfg.rate_even      <= pwdata[23:0];
        sjag_pkg::REG_RATE_ODD:   cfg.rate_odd       <= pwdata[23:0];
        sjag_pkg::REG_STEP_EVEN:  cfg.step_even      <= pwdata[15:0];
        sjag_pkg::REG_STEP_ODD:   cfg.step_odd       <= pwdata[15:0];
        sjag_pkg::REG_ODD_OFFSET: cfg.odd_offset     <= pwdata[15:0];
        sjag_pkg::REG_REVERSE:    cfg.reverse        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sjag_pkg::REG_AMP_EVEN:   prdata = {16'b0, cfg.amplitude_even};
      sjag_pkg::REG_AMP_ODD:    prdata = {16'b0, cfg.amplitude_odd};
      sjag_pkg::REG_RATE_EVEN:  prdata = {8'b0, cfg.rate_even};
      sjag_pkg::REG_RATE_ODD:   prdata = {8'b0, cfg.rate_odd};
      sjag_pkg::REG_STEP_EVEN:  prdata = {16'b0, cfg.step_even};
      sjag_pkg::REG_STEP_ODD:   prdata = {16'b0, cfg.step_odd};
      sjag_pkg::REG_ODD_OFFSET: prdata = {16'b0, cfg.odd_offset};
      sjag_pkg::REG_REVERSE:    prdata = {31'b0, cfg.reverse};
      default:                  prdata = '0;
    endcase
  end

endmodule

/* sv/sjag_phase.sv */
// Phase front end: time and joint terms (one stage), then sum, truncation and
// quadrant fold into a CORDIC start vector (second stage). Depends on sjag_pkg.
`timescale 1ns / 1ps

module sjag_phase (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  sjag_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  input  logic [sjag_pkg::JOINT_W-1:0] joint_index,
  input  logic [sjag_pkg::TIME_W-1:0]  time_stamp,
  output sjag_pkg::cordic_t            start
);

  localparam int PW = sjag_pkg::PHASE_W;
  localparam int CW = sjag_pkg::CW;

  // First stage: products.
  logic                                         odd;
  logic [sjag_pkg::RATE_W-1:0]                  rate_sel;
  logic [sjag_pkg::STEP_W-1:0]                  step_sel;
  logic [sjag_pkg::RATE_W+sjag_pkg::TIME_W-1:0] time_prod;
  logic [sjag_pkg::JOINT_W+sjag_pkg::STEP_W-1:0] lag_prod;
  logic [PW-1:0]                                lag_term;

  logic                         a_valid;
  logic [sjag_pkg::JOINT_W-1:0] a_joint;
  logic [PW-1:0]                a_time_term;
  logic [PW-1:0]                a_lag_term;
  logic [sjag_pkg::STEP_W-1:0]  a_offset;

  assign odd       = joint_index[0];
  assign rate_sel  = odd ? cfg.rate_odd : cfg.rate_even;
  assign step_sel  = odd ? cfg.step_odd : cfg.step_even;
  assign time_prod = rate_sel * time_stamp;
  assign lag_prod  = joint_index * step_sel;

  always_comb begin
    lag_term = {lag_prod[15:0], 16'b0};
    if (cfg.reverse) begin
      lag_term = PW'(0) - lag_term;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid     <= in_valid;
      a_joint     <= joint_index;
      a_time_term <= time_prod[PW-1:0];
      a_lag_term  <= lag_term;
      a_offset    <= odd ? cfg.odd_offset : '0;
    end
  end

  // Second stage: wrap-around sum and fold into the right half plane.
  logic [PW-1:0]        phase;
  logic signed [CW-1:0] z_full;
  logic signed [CW-1:0] z_fold;
  logic                 neg_fold;

  assign phase  = (a_time_term + a_lag_term + {a_offset, 16'b0}) & sjag_pkg::PHASE_MASK;
  assign z_full = {{(CW-PW){phase[PW-1]}}, phase};

  always_comb begin
    z_fold   = z_full;
    neg_fold = 1'b0;
    if (z_full > sjag_pkg::QUARTER_TURN) begin
      z_fold   = z_full - sjag_pkg::HALF_TURN;
      neg_fold = 1'b1;
    end else if (z_full < -sjag_pkg::QUARTER_TURN) begin
      z_fold   = z_full + sjag_pkg::HALF_TURN;
      neg_fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start.valid <= 1'b0;
    end else if (en) begin
      start.valid <= a_valid;
      start.joint <= a_joint;
      start.neg   <= neg_fold;
      start.x     <= sjag_pkg::CORDIC_X0;
      start.y     <= '0;
      start.z     <= z_fold;
    end
  end

endmodule

/* sv/sjag_cordic.sv */
// Rotation-mode CORDIC, one register stage per iteration.
// Depends on sjag_pkg.
`timescale 1ns / 1ps

module sjag_cordic (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  sjag_pkg::cordic_t start,
  output sjag_pkg::cordic_t result
);

  localparam int N  = sjag_pkg::CORDIC_STAGES;
  localparam int CW = sjag_pkg::CW;

  sjag_pkg::cordic_t pipe [N+1];

  assign pipe[0] = start;
  assign result  = pipe[N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    sjag_pkg::cordic_t    stage_q;
    logic signed [CW-1:0] xi, yi, zi, dx, dy, ang;

    assign xi  = pipe[i].x;
    assign yi  = pipe[i].y;
    assign zi  = pipe[i].z;
    // Arithmetic shifts round toward minus infinity.
    assign dx  = yi >>> i;
    assign dy  = xi >>> i;
    assign ang = sjag_pkg::atan_turn(sjag_pkg::STAGE_IDX_W'(i));

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_q.valid <= 1'b0;
      end else if (en) begin
        stage_q.valid <= pipe[i].valid;
        stage_q.joint <= pipe[i].joint;
        stage_q.neg   <= pipe[i].neg;
        if (!zi[CW-1]) begin
          stage_q.x <= xi - dx;
          stage_q.y <= yi + dy;
          stage_q.z <= zi - ang;
        end else begin
          stage_q.x <= xi + dx;
          stage_q.y <= yi - dy;
          stage_q.z <= zi + ang;
        end
      end
    end

    assign pipe[i+1] = stage_q;
  end

endmodule

/* sv/sjag_scale.sv */
// Amplitude scaling: sine magnitude times amplitude (one stage), then rounding,
// clamping and sign into the output register (second stage). Depends on sjag_pkg.
`timescale 1ns / 1ps

module sjag_scale (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  sjag_pkg::cfg_t                      cfg,
  input  sjag_pkg::cordic_t                   rot,
  output logic                                out_valid,
  output logic signed [sjag_pkg::ANGLE_W-1:0] angle,
  output logic [sjag_pkg::JOINT_W-1:0]        joint
);

  localparam int CW     = sjag_pkg::CW;
  localparam int MAG_W  = sjag_pkg::MAG_W;
  localparam int AMP_W  = sjag_pkg::AMP_W;
  localparam int PROD_W = sjag_pkg::PROD_W;

  logic [CW-1:0]    y_abs;
  logic [AMP_W-1:0] amp_sel;

  assign y_abs   = rot.y[CW-1] ? CW'(-rot.y) : CW'(rot.y);
  assign amp_sel = rot.joint[0] ? cfg.amplitude_odd : cfg.amplitude_even;

  logic                         m_valid;
  logic [sjag_pkg::JOINT_W-1:0] m_joint;
  logic                         m_neg;
  logic [AMP_W-1:0]             m_amp;
  logic [PROD_W-1:0]            m_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= rot.valid;
      m_joint <= rot.joint;
      m_neg   <= rot.neg ^ rot.y[CW-1];
      m_amp   <= amp_sel;
      m_prod  <= amp_sel * y_abs[MAG_W-1:0];
    end
  end

  logic [PROD_W:0]      rounded;
  logic [18:0]          mag;
  logic [AMP_W-1:0]     mag_clamped;
  logic [sjag_pkg::ANGLE_W-1:0] mag_ext;

  assign rounded     = {1'b0, m_prod} + sjag_pkg::ROUND_HALF;
  assign mag         = rounded[PROD_W:30];
  assign mag_clamped = (mag > {3'b0, m_amp}) ? m_amp : mag[AMP_W-1:0];
  assign mag_ext     = {1'b0, mag_clamped};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_valid;
      joint     <= m_joint;
      angle     <= m_neg ? -$signed(mag_ext) : $signed(mag_ext);
    end
  end

endmodule

/* sv/sidewinding_joint_angle_gen.sv */
// Sidewinding joint angle generator: an input transfer passes through to the result on the output
// by way of 2 phase stages, 24 CORDIC stages and 2 scaling stages.
// Throughput is one item per cycle; a stalled output register freezes the whole pipeline.
// Reset (rst, synchronous) empties the pipeline and loads the register reset values.
// Depends on sjag_pkg, sjag_regs, sjag_phase, sjag_cordic and sjag_scale.
`timescale 1ns / 1ps

module sidewinding_joint_angle_gen (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [39:0]                 s_tdata,  // joint_index[5:0], time_stamp[37:6], zero pad
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [23:0]                 m_tdata,  // target_angle[16:0], joint_echo[22:17], zero pad
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sjag_pkg::ADDR_W-1:0] paddr,
  input  logic [sjag_pkg::DATA_W-1:0] pwdata,
  output logic [sjag_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  sjag_pkg::cfg_t                      cfg;
  sjag_pkg::cordic_t                   start;
  sjag_pkg::cordic_t                   rot;
  logic                                en;
  logic signed [sjag_pkg::ANGLE_W-1:0] angle_out;
  logic [sjag_pkg::JOINT_W-1:0]        joint_out;

  // The pipeline advances whenever the output register is empty or being taken.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tdata  = {1'b0, joint_out, angle_out};

  sjag_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sjag_phase u_phase (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .joint_index (s_tdata[5:0]),
    .time_stamp  (s_tdata[37:6]),
    .start       (start)
  );

  sjag_cordic u_cordic (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .start  (start),
    .result (rot)
  );

  sjag_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .rot       (rot),
    .out_valid (m_tvalid),
    .angle     (angle_out),
    .joint     (joint_out)
  );

  logic [sjag_pkg::AMP_W-1:0]          amp_chk;
  logic signed [sjag_pkg::ANGLE_W-1:0] amp_signed;

  assign amp_chk    = joint_out[0] ? cfg.amplitude_odd : cfg.amplitude_even;
  assign amp_signed = $signed({1'b0, amp_chk});

  a_reset_empties: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_angle_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (angle_out <= amp_signed) && (angle_out >= -amp_signed))
    else $error("target angle exceeds the joint's amplitude");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> u_phase.a_valid)
    else $error("accepted item did not enter the phase stage");

endmodule

/* verif/tb_sidewinding_joint_angle_gen.sv */
// Self-checking testbench for sidewinding_joint_angle_gen: a directed table of joint requests,
// then random configurations and requests, with every result checked in order against
// a typed table angle or an in-bench CORDIC predictor. Depends on sjag_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_sidewinding_joint_angle_gen;

  localparam int JOINTS       = 10;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RAND_PHASES  = 7;
  localparam int PHASE_ITEMS  = 250;
  localparam int DIR_ROWS     = 20;
  localparam int ROT_STAGES   = 24;
  localparam longint ROT_X0   = 652032874;
  localparam longint QTURN    = 64'sd1073741824;
  localparam longint HTURN    = 64'sd2147483648;
  localparam logic [sjag_pkg::AMP_W-1:0] AMP_MAX  = 16'd46080;
  localparam logic [sjag_pkg::AMP_W-1:0] AMP_OVER = 16'hFFFF;

  // atan(2^-i) in units of 2^-32 turn.
  localparam longint ROT_ATAN [0:ROT_STAGES-1] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335086, 667544, 333772,
    166886, 83443, 41721, 20860, 10430, 5215,
    2607, 1303, 651, 325, 162, 81
  };

  typedef struct packed {
    logic signed [sjag_pkg::ANGLE_W-1:0] angle;
    logic [sjag_pkg::JOINT_W-1:0]        joint;
  } angle_rec_t;

  typedef struct packed {
    logic [1:0]                          set;
    logic [sjag_pkg::JOINT_W-1:0]        joint;
    logic [sjag_pkg::TIME_W-1:0]         stamp;
    logic                                typed;
    logic signed [sjag_pkg::ANGLE_W-1:0] angle;
  } dir_row_t;

  logic                          clk      = 1'b0;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [39:0]                   s_tdata  = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [23:0]                   m_tdata;
  logic                          psel     = 1'b0;
  logic                          penable  = 1'b0;
  logic                          pwrite   = 1'b0;
  logic [sjag_pkg::ADDR_W-1:0]   paddr    = '0;
  logic [sjag_pkg::DATA_W-1:0]   pwdata   = '0;
  logic [sjag_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  sjag_pkg::cfg_t cur_cfg;
  angle_rec_t     expected_q [$];
  int             miss_count = 0;
  int             idle_cycles = 0;
  bit             no_gaps = 1'b0;

  // Set 0 is the reset state, set 1 puts the four quadrant points on clean phases,
  // set 2 drives every field to its far end, set 3 mixes them with reverse direction.
  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    '{2'd0, 6'd0,  32'h0000_0000, 1'b1, 17'sd0},
    '{2'd0, 6'd1,  32'h0000_0000, 1'b0, 17'sd0},
    '{2'd0, 6'd63, 32'hFFFF_FFFF, 1'b0, 17'sd0},
    '{2'd0, 6'd10, 32'h0001_0000, 1'b0, 17'sd0},
    '{2'd0, 6'd9,  32'h8000_0000, 1'b0, 17'sd0},
    '{2'd0, 6'd62, 32'h0000_FFFF, 1'b0, 17'sd0},
    '{2'd1, 6'd0,  32'h0000_0000, 1'b1, 17'sd0},
    '{2'd1, 6'd0,  32'h0000_4000, 1'b1, 17'sd46080},
    '{2'd1, 6'd0,  32'h0000_8000, 1'b1, 17'sd0},
    '{2'd1, 6'd0,  32'h0000_C000, 1'b1, -17'sd46080},
    '{2'd1, 6'd1,  32'h0000_4000, 1'b1, 17'sd65535},
    '{2'd1, 6'd1,  32'h0000_C000, 1'b1, -17'sd65535},
    '{2'd1, 6'd2,  32'h0001_2345, 1'b0, 17'sd0},
    '{2'd2, 6'd63, 32'hFFFF_FFFF, 1'b1, 17'sd0},
    '{2'd2, 6'd0,  32'h0000_0000, 1'b1, 17'sd0},
    '{2'd2, 6'd1,  32'hFFFF_FFFF, 1'b1, 17'sd0},
    '{2'd3, 6'd3,  32'hDEAD_BEEF, 1'b0, 17'sd0},
    '{2'd3, 6'd4,  32'h0001_0000, 1'b0, 17'sd0},
    '{2'd3, 6'd63, 32'hFFFF_FFFF, 1'b0, 17'sd0},
    '{2'd3, 6'd7,  32'h7FFF_FFFF, 1'b0, 17'sd0}
  };

  sidewinding_joint_angle_gen u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Target angle of one joint: amplitude times the CORDIC sine of the summed phase.
  function automatic logic signed [sjag_pkg::ANGLE_W-1:0] joint_angle(
      input sjag_pkg::cfg_t c, input logic [sjag_pkg::JOINT_W-1:0] j,
      input logic [sjag_pkg::TIME_W-1:0] t);
    logic                       odd;
    logic [63:0]                prod;
    logic [31:0]                phase;
    logic [31:0]                lag;
    logic [sjag_pkg::AMP_W-1:0] amp;
    longint                     z;
    longint                     x;
    longint                     y;
    longint                     dx;
    longint                     dy;
    longint                     mag;
    bit                         neg;
    odd   = j[0];
    amp   = odd ? c.amplitude_odd : c.amplitude_even;
    prod  = 64'(odd ? c.rate_odd : c.rate_even) * 64'(t);
    phase = prod[31:0];
    lag   = 32'(32'(j) * 32'(odd ? c.step_odd : c.step_even)) << 16;
    if (c.reverse) begin
      lag = 32'd0 - lag;
    end
    phase = phase + lag;
    if (odd) begin
      phase = phase + {c.odd_offset, 16'h0000};
    end
    phase = (phase >> (32 - sjag_pkg::PHASE_BITS)) << (32 - sjag_pkg::PHASE_BITS);

    // Fold the phase into the right half-plane, where the rotation converges.
    z   = longint'($signed(phase));
    neg = 1'b0;
    if (z > QTURN) begin
      z   = z - HTURN;
      neg = 1'b1;
    end else if (z < -QTURN) begin
      z   = z + HTURN;
      neg = 1'b1;
    end
    x = ROT_X0;
    y = 0;
    for (int i = 0; i < ROT_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ROT_ATAN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ROT_ATAN[i];
      end
    end
    if (y < 0) begin
      neg = !neg;
      mag = -y;
    end else begin
      mag = y;
    end
    mag = (longint'(amp) * mag + (64'sd1 << 29)) >>> 30;
    if (mag > longint'(amp)) begin
      mag = longint'(amp);
    end
    return sjag_pkg::ANGLE_W'(neg ? -mag : mag);
  endfunction

  function automatic logic [sjag_pkg::AMP_W-1:0] pick_amp();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return AMP_MAX;
      2: return AMP_OVER;
      default: return sjag_pkg::AMP_W'($urandom_range(0, 46080));
    endcase
  endfunction

  function automatic logic [sjag_pkg::RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return sjag_pkg::RATE_W'($urandom_range(0, 255));
      default: return sjag_pkg::RATE_W'($urandom);
    endcase
  endfunction

  function automatic sjag_pkg::cfg_t dir_cfg(input logic [1:0] set);
    sjag_pkg::cfg_t c;
    c.amplitude_even = sjag_pkg::AMP_EVEN_RST;
    c.amplitude_odd  = sjag_pkg::AMP_ODD_RST;
    c.rate_even      = sjag_pkg::RATE_RST;
    c.rate_odd       = sjag_pkg::RATE_RST;
    c.step_even      = sjag_pkg::STEP_RST;
    c.step_odd       = sjag_pkg::STEP_RST;
    c.odd_offset     = '0;
    c.reverse        = 1'b0;
    case (set)
      2'd1: begin
        c.amplitude_even = AMP_MAX;
        c.amplitude_odd  = AMP_OVER;
        c.rate_even      = 24'd65536;
        c.rate_odd       = 24'd65536;
        c.step_even      = '0;
        c.step_odd       = '0;
      end
      2'd2: begin
        c.amplitude_even = '0;
        c.amplitude_odd  = '0;
        c.rate_even      = '1;
        c.rate_odd       = '1;
        c.step_even      = '1;
        c.step_odd       = '1;
        c.odd_offset     = '1;
        c.reverse        = 1'b1;
      end
      2'd3: begin
        c.amplitude_even = AMP_MAX;
        c.amplitude_odd  = AMP_MAX;
        c.rate_even      = 24'd1;
        c.rate_odd       = '1;
        c.step_even      = '1;
        c.step_odd       = 16'd1;
        c.odd_offset     = 16'h8000;
        c.reverse        = 1'b1;
      end
      default: ;
    endcase
    return c;
  endfunction

  // Setup and access cycles; psel is left high so that writes can follow back to back.
  task automatic write_reg(input sjag_pkg::reg_idx_t idx,
      input logic [sjag_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
  endtask

  task automatic apply_cfg(input sjag_pkg::cfg_t c);
    write_reg(sjag_pkg::REG_AMP_EVEN,   sjag_pkg::DATA_W'(c.amplitude_even));
    write_reg(sjag_pkg::REG_AMP_ODD,    sjag_pkg::DATA_W'(c.amplitude_odd));
    write_reg(sjag_pkg::REG_RATE_EVEN,  sjag_pkg::DATA_W'(c.rate_even));
    write_reg(sjag_pkg::REG_RATE_ODD,   sjag_pkg::DATA_W'(c.rate_odd));
    write_reg(sjag_pkg::REG_STEP_EVEN,  sjag_pkg::DATA_W'(c.step_even));
    write_reg(sjag_pkg::REG_STEP_ODD,   sjag_pkg::DATA_W'(c.step_odd));
    write_reg(sjag_pkg::REG_ODD_OFFSET, sjag_pkg::DATA_W'(c.odd_offset));
    write_reg(sjag_pkg::REG_REVERSE,    sjag_pkg::DATA_W'(c.reverse));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic wait_results();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // tvalid stays high across back-to-back transfers and drops only for a gap.
  task automatic send_joint(input logic [sjag_pkg::JOINT_W-1:0] j,
      input logic [sjag_pkg::TIME_W-1:0] t, input logic typed,
      input logic signed [sjag_pkg::ANGLE_W-1:0] typed_angle);
    int         gap;
    angle_rec_t rec;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, t, j};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    rec.joint = j;
    rec.angle = typed ? typed_angle : joint_angle(cur_cfg, j, t);
    expected_q.push_back(rec);
  endtask

  initial begin
    logic [1:0]                   cur_set;
    sjag_pkg::cfg_t               c;
    logic [sjag_pkg::JOINT_W-1:0] j;
    logic [sjag_pkg::TIME_W-1:0]  t;
    cur_cfg = dir_cfg(2'd0);
    cur_set = 2'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].set != cur_set) begin
        s_tvalid <= 1'b0;
        wait_results();
        apply_cfg(dir_cfg(dir_tab[i].set));
        cur_set = dir_tab[i].set;
      end
      send_joint(dir_tab[i].joint, dir_tab[i].stamp, dir_tab[i].typed, dir_tab[i].angle);
    end
    s_tvalid <= 1'b0;

    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_results();
      c.amplitude_even = pick_amp();
      c.amplitude_odd  = pick_amp();
      c.rate_even      = pick_rate();
      c.rate_odd       = pick_rate();
      c.step_even      = sjag_pkg::STEP_W'($urandom);
      c.step_odd       = sjag_pkg::STEP_W'($urandom);
      c.odd_offset     = sjag_pkg::STEP_W'($urandom);
      c.reverse        = 1'($urandom_range(0, 1));
      apply_cfg(c);
      no_gaps = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        j = ($urandom_range(0, 3) == 0) ? sjag_pkg::JOINT_W'($urandom_range(0, 63))
                                        : sjag_pkg::JOINT_W'($urandom_range(0, JOINTS - 1));
        case ($urandom_range(0, 9))
          0: t = '1;
          1: t = sjag_pkg::TIME_W'($urandom_range(0, 65535));
          default: t = $urandom;
        endcase
        send_joint(j, t, 1'b0, '0);
      end
      s_tvalid <= 1'b0;
    end

    wait_results();
    repeat (40) @(posedge clk);
    if (miss_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result side: a random stall before each transfer, none while no_gaps is set.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (m_tvalid !== 1'b1);
      @(posedge clk);
    end
  end

  // Outputs settle by the falling edge; a transfer seen here completes at the next rising edge.
  always @(negedge clk) begin
    angle_rec_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        miss_count++;
        if (miss_count <= 10) begin
          $display("unexpected result: angle %0d joint %0d",
                   $signed(m_tdata[16:0]), m_tdata[22:17]);
        end
      end else begin
        want = expected_q.pop_front();
        if (m_tdata[16:0] !== want.angle || m_tdata[22:17] !== want.joint) begin
          miss_count++;
          if (miss_count <= 10) begin
            $display("mismatch: expected angle %0d joint %0d, got angle %0d joint %0d",
                     want.angle, want.joint, $signed(m_tdata[16:0]), m_tdata[22:17]);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

/* filelist.f */
sv/sjag_pkg.sv
sv/sjag_regs.sv
sv/sjag_phase.sv
sv/sjag_cordic.sv
sv/sjag_scale.sv
sv/sidewinding_joint_angle_gen.sv
verif/tb_sidewinding_joint_angle_gen.sv
